@@ src/xxh64_pkg.sv @@
// Package for the streaming XXH64 hasher: constants, datapath commands, FSM states.
// No dependencies.
package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LANE_MUL,
        ST_LANE_ROT,
        ST_LANE_MUL1,
        ST_LANE_WB,
        ST_MRG_SUM,
        ST_MRG_MUL,
        ST_MRG_ROT,
        ST_MRG_MUL1,
        ST_MRG_MUL2,
        ST_NOMRG,
        ST_ADDLEN,
        ST_W8_MUL,
        ST_W8_ROT,
        ST_W8_MUL1,
        ST_W8_MUL2,
        ST_W4_MUL,
        ST_W4_MUL2,
        ST_B1_MUL,
        ST_B1_MUL2,
        ST_FM_MUL,
        ST_FM_MUL2,
        ST_FM_END,
        ST_OUT
    } state_t;

    // one-cycle datapath commands issued by the controller
    typedef struct packed {
        logic       start_msg;
        logic       accept;
        logic       buf_word;
        state_t     step;
        logic [1:0] phase;
        logic [1:0] sel;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic       stripe_full;
        logic       stripe_seen;
        logic [1:0] position;
        logic [3:0] bv;
    } status_t;

    // steps that use the shared multiplier
    function automatic logic is_mul_step(input state_t s);
        is_mul_step = s inside {ST_LANE_MUL, ST_LANE_MUL1, ST_MRG_MUL, ST_MRG_MUL1,
                                ST_MRG_MUL2, ST_W8_MUL, ST_W8_MUL1, ST_W8_MUL2,
                                ST_W4_MUL, ST_W4_MUL2, ST_B1_MUL, ST_B1_MUL2,
                                ST_FM_MUL, ST_FM_MUL2};
    endfunction

endpackage

@@ src/xxh64_datapath.sv @@
// Datapath of the XXH64 hasher: lanes, stripe buffer, byte count, hash register.
// Uses xxh64_pkg; driven by xxh64_ctrl commands, one 32x32 partial product per cycle.
module xxh64_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         seed,
    input  logic [63:0]         data_word,
    input  logic [3:0]          bytes_valid,
    input  logic                last,
    input  xxh64_pkg::cmd_t     cmd,
    output xxh64_pkg::status_t  status,
    output logic [63:0]         digest
);

    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [3];
    logic [63:0] word_reg;
    logic [3:0]  bv_reg;
    logic        last_reg;
    logic [1:0]  pos_reg;
    logic        seen_reg;
    logic [63:0] count_reg;
    logic [63:0] h_reg;
    logic [63:0] t_reg;
    logic [63:0] prod_reg;
    logic [3:0]  bv_in;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] prod;

    assign bv_in = (!last) ? 4'd8 : ((bytes_valid > 4'd8) ? 4'd8 : bytes_valid);

    assign status.last        = last_reg;
    assign status.stripe_full = (pos_reg == 2'd3) && (bv_reg == 4'd8);
    assign status.stripe_seen = seen_reg;
    assign status.position    = pos_reg;
    assign status.bv          = bv_reg;
    assign digest             = h_reg;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
        rotl = (v << n) | (v >> (64 - n));
    endfunction

    logic [63:0] src_word;
    always_comb
    begin
        case (cmd.sel)
            2'd0:    src_word = buf_reg[0];
            2'd1:    src_word = buf_reg[1];
            2'd2:    src_word = buf_reg[2];
            default: src_word = word_reg;
        endcase
    end

    always_comb
    begin
        mul_a = t_reg;
        mul_b = xxh64_pkg::PRIME1;
        case (cmd.step)
            xxh64_pkg::ST_LANE_MUL, xxh64_pkg::ST_W8_MUL:
            begin
                mul_a = src_word;
                mul_b = xxh64_pkg::PRIME2;
            end
            xxh64_pkg::ST_MRG_MUL:
            begin
                mul_a = lane_reg[cmd.lane];
                mul_b = xxh64_pkg::PRIME2;
            end
            xxh64_pkg::ST_MRG_MUL2, xxh64_pkg::ST_W8_MUL2, xxh64_pkg::ST_B1_MUL2:
                mul_a = h_reg;
            xxh64_pkg::ST_W4_MUL:
                mul_a = {32'd0, word_reg[31:0]};
            xxh64_pkg::ST_W4_MUL2:
            begin
                mul_a = h_reg;
                mul_b = xxh64_pkg::PRIME2;
            end
            xxh64_pkg::ST_B1_MUL:
            begin
                mul_a = {56'd0, word_reg[7:0]};
                mul_b = xxh64_pkg::PRIME5;
            end
            xxh64_pkg::ST_FM_MUL:
            begin
                mul_a = h_reg ^ (h_reg >> 33);
                mul_b = xxh64_pkg::PRIME2;
            end
            xxh64_pkg::ST_FM_MUL2:
            begin
                mul_a = h_reg ^ (h_reg >> 29);
                mul_b = xxh64_pkg::PRIME3;
            end
            default: ;
        endcase
    end

    // low 64 bits of a*b: lo*lo, then lo*hi and hi*lo shifted up by 32
    always_comb
    begin
        case (cmd.phase)
            2'd0:
            begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[31:0];
            end
            2'd1:
            begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[63:32];
            end
            default:
            begin
                mul_x = mul_a[63:32];
                mul_y = mul_b[31:0];
            end
        endcase
    end

    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};
    assign prod  = prod_reg + {mul_p[31:0], 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            seen_reg  <= 1'b0;
            count_reg <= 64'd0;
            last_reg  <= 1'b0;
            bv_reg    <= 4'd0;
            word_reg  <= 64'd0;
            h_reg     <= 64'd0;
            t_reg     <= 64'd0;
            prod_reg  <= 64'd0;
            buf_reg[0] <= 64'd0;
            buf_reg[1] <= 64'd0;
            buf_reg[2] <= 64'd0;
            lane_reg[0] <= xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
            lane_reg[1] <= xxh64_pkg::PRIME2;
            lane_reg[2] <= 64'd0;
            lane_reg[3] <= 64'd0 - xxh64_pkg::PRIME1;
        end
        else
        begin
            if (cmd.accept)
            begin
                word_reg <= data_word;
                bv_reg   <= bv_in;
                last_reg <= last;
                if (cmd.start_msg)
                begin
                    lane_reg[0] <= seed + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
                    lane_reg[1] <= seed + xxh64_pkg::PRIME2;
                    lane_reg[2] <= seed;
                    lane_reg[3] <= seed - xxh64_pkg::PRIME1;
                    count_reg   <= {60'd0, bv_in};
                    pos_reg     <= 2'd0;
                    seen_reg    <= 1'b0;
                end
                else
                begin
                    count_reg <= count_reg + {60'd0, bv_in};
                end
            end
            if (cmd.buf_word)
            begin
                buf_reg[pos_reg] <= word_reg;
                pos_reg <= pos_reg + 2'd1;
            end
            if (xxh64_pkg::is_mul_step(cmd.step) && (cmd.phase != 2'd2))
                prod_reg <= (cmd.phase == 2'd0) ? mul_p : prod;
            else
            begin
                case (cmd.step)
                    xxh64_pkg::ST_LANE_MUL, xxh64_pkg::ST_LANE_MUL1,
                    xxh64_pkg::ST_MRG_MUL, xxh64_pkg::ST_W8_MUL:
                        t_reg <= prod;
                    xxh64_pkg::ST_LANE_ROT:  t_reg <= rotl(lane_reg[cmd.lane] + t_reg, 31);
                    xxh64_pkg::ST_LANE_WB:
                    begin
                        lane_reg[cmd.lane] <= t_reg;
                        if (cmd.lane == 2'd3)
                        begin
                            pos_reg  <= 2'd0;
                            seen_reg <= 1'b1;
                            if (last_reg)
                                bv_reg <= 4'd0;
                        end
                    end
                    xxh64_pkg::ST_MRG_SUM:
                        h_reg <= rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7)
                               + rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);
                    xxh64_pkg::ST_MRG_ROT:   t_reg <= rotl(t_reg, 31);
                    xxh64_pkg::ST_MRG_MUL1:  h_reg <= h_reg ^ prod;
                    xxh64_pkg::ST_MRG_MUL2:  h_reg <= prod + xxh64_pkg::PRIME4;
                    xxh64_pkg::ST_NOMRG:     h_reg <= lane_reg[2] + xxh64_pkg::PRIME5;
                    xxh64_pkg::ST_ADDLEN:    h_reg <= h_reg + count_reg;
                    xxh64_pkg::ST_W8_ROT:    t_reg <= rotl(t_reg, 31);
                    xxh64_pkg::ST_W8_MUL1:   h_reg <= rotl(h_reg ^ prod, 27);
                    xxh64_pkg::ST_W8_MUL2:   h_reg <= prod + xxh64_pkg::PRIME4;
                    xxh64_pkg::ST_W4_MUL:    h_reg <= rotl(h_reg ^ prod, 23);
                    xxh64_pkg::ST_W4_MUL2:
                    begin
                        h_reg    <= prod + xxh64_pkg::PRIME3;
                        word_reg <= {32'd0, word_reg[63:32]};
                        bv_reg   <= bv_reg - 4'd4;
                    end
                    xxh64_pkg::ST_B1_MUL:    h_reg <= rotl(h_reg ^ prod, 11);
                    xxh64_pkg::ST_B1_MUL2:
                    begin
                        h_reg    <= prod;
                        word_reg <= {8'd0, word_reg[63:8]};
                        bv_reg   <= bv_reg - 4'd1;
                    end
                    xxh64_pkg::ST_FM_MUL:    h_reg <= prod;
                    xxh64_pkg::ST_FM_MUL2:   h_reg <= prod;
                    xxh64_pkg::ST_FM_END:
                    begin
                        h_reg    <= h_reg ^ (h_reg >> 32);
                        pos_reg  <= 2'd0;
                        seen_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ src/xxh64_ctrl.sv @@
// Controller FSM of the XXH64 hasher: sequences lane rounds, merge, tail and mix.
// Uses xxh64_pkg; drives xxh64_datapath through cmd_t / status_t.
module xxh64_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output xxh64_pkg::cmd_t     cmd,
    input  xxh64_pkg::status_t  status
);

    xxh64_pkg::state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       in_msg_reg, in_msg_next;
    logic       merged_reg, merged_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xxh64_pkg::ST_IDLE;
            cnt_reg    <= 2'd0;
            phase_reg  <= 2'd0;
            in_msg_reg <= 1'b0;
            merged_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            in_msg_reg <= in_msg_next;
            merged_reg <= merged_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        phase_next  = 2'd0;
        in_msg_next = in_msg_reg;
        merged_next = merged_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.step    = state_reg;
        cmd.phase   = phase_reg;
        cmd.sel     = cnt_reg;
        cmd.lane    = cnt_reg;
        case (state_reg)
            xxh64_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.step = xxh64_pkg::ST_IDLE;
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.start_msg = !in_msg_reg;
                    in_msg_next   = 1'b1;
                    cnt_next      = 2'd0;
                    merged_next   = 1'b0;
                    state_next    = xxh64_pkg::ST_LANE_MUL;
                end
            end
            xxh64_pkg::ST_LANE_MUL:
            begin
                // only a full stripe goes through the lanes
                if (!(status.stripe_full || (!status.last && status.position == 2'd3)))
                begin
                    cmd.step = xxh64_pkg::ST_IDLE;
                    if (!status.last)
                    begin
                        cmd.buf_word = 1'b1;
                        state_next   = xxh64_pkg::ST_IDLE;
                    end
                    else
                        state_next = status.stripe_seen ? xxh64_pkg::ST_MRG_SUM
                                                        : xxh64_pkg::ST_NOMRG;
                end
                else
                    state_next = xxh64_pkg::ST_LANE_ROT;
            end
            xxh64_pkg::ST_LANE_ROT:  state_next = xxh64_pkg::ST_LANE_MUL1;
            xxh64_pkg::ST_LANE_MUL1: state_next = xxh64_pkg::ST_LANE_WB;
            xxh64_pkg::ST_LANE_WB:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg != 2'd3)
                    state_next = xxh64_pkg::ST_LANE_MUL;
                else if (!status.last)
                    state_next = xxh64_pkg::ST_IDLE;
                else
                    state_next = xxh64_pkg::ST_MRG_SUM;
            end
            xxh64_pkg::ST_MRG_SUM:
            begin
                cnt_next   = 2'd0;
                state_next = xxh64_pkg::ST_MRG_MUL;
            end
            xxh64_pkg::ST_MRG_MUL:  state_next = xxh64_pkg::ST_MRG_ROT;
            xxh64_pkg::ST_MRG_ROT:  state_next = xxh64_pkg::ST_MRG_MUL1;
            xxh64_pkg::ST_MRG_MUL1: state_next = xxh64_pkg::ST_MRG_MUL2;
            xxh64_pkg::ST_MRG_MUL2:
            begin
                cnt_next   = cnt_reg + 2'd1;
                state_next = (cnt_reg == 2'd3) ? xxh64_pkg::ST_ADDLEN
                                               : xxh64_pkg::ST_MRG_MUL;
            end
            xxh64_pkg::ST_NOMRG: state_next = xxh64_pkg::ST_ADDLEN;
            xxh64_pkg::ST_ADDLEN:
            begin
                cnt_next   = 2'd0;
                state_next = xxh64_pkg::ST_W8_MUL;
            end
            xxh64_pkg::ST_W8_MUL:
            begin
                // buffered words first, then the last word if it is full
                if (!merged_reg && cnt_reg < status.position)
                    state_next = xxh64_pkg::ST_W8_ROT;
                else if (!merged_reg && status.bv == 4'd8)
                begin
                    cmd.sel    = 2'd3;
                    merged_next = 1'b1;
                    state_next = xxh64_pkg::ST_W8_ROT;
                end
                else
                begin
                    cmd.step   = xxh64_pkg::ST_IDLE;
                    state_next = (status.bv >= 4'd4 && status.bv != 4'd8)
                                 ? xxh64_pkg::ST_W4_MUL : xxh64_pkg::ST_B1_MUL;
                end
            end
            xxh64_pkg::ST_W8_ROT:  state_next = xxh64_pkg::ST_W8_MUL1;
            xxh64_pkg::ST_W8_MUL1: state_next = xxh64_pkg::ST_W8_MUL2;
            xxh64_pkg::ST_W8_MUL2:
            begin
                if (merged_reg)
                    state_next = xxh64_pkg::ST_FM_MUL;
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = xxh64_pkg::ST_W8_MUL;
                end
            end
            xxh64_pkg::ST_W4_MUL:  state_next = xxh64_pkg::ST_W4_MUL2;
            xxh64_pkg::ST_W4_MUL2: state_next = xxh64_pkg::ST_B1_MUL;
            xxh64_pkg::ST_B1_MUL:
            begin
                if (status.bv == 4'd0 || merged_reg)
                begin
                    cmd.step   = xxh64_pkg::ST_IDLE;
                    state_next = xxh64_pkg::ST_FM_MUL;
                end
                else
                    state_next = xxh64_pkg::ST_B1_MUL2;
            end
            xxh64_pkg::ST_B1_MUL2: state_next = xxh64_pkg::ST_B1_MUL;
            xxh64_pkg::ST_FM_MUL:  state_next = xxh64_pkg::ST_FM_MUL2;
            xxh64_pkg::ST_FM_MUL2: state_next = xxh64_pkg::ST_FM_END;
            xxh64_pkg::ST_FM_END:
            begin
                in_msg_next = 1'b0;
                state_next  = xxh64_pkg::ST_OUT;
            end
            xxh64_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.step  = xxh64_pkg::ST_IDLE;
                if (out_ready)
                    state_next = xxh64_pkg::ST_IDLE;
            end
            default: state_next = xxh64_pkg::ST_IDLE;
        endcase
        // a multiply step holds until its last partial-product phase
        if (xxh64_pkg::is_mul_step(cmd.step) && (phase_reg != 2'd2))
        begin
            state_next  = state_reg;
            cnt_next    = cnt_reg;
            in_msg_next = in_msg_reg;
            merged_next = merged_reg;
            phase_next  = phase_reg + 2'd1;
        end
    end

endmodule

@@ src/xxhash64_stream_hasher_unit.sv @@
// Top level of the streaming XXH64 hasher.
// Uses xxh64_pkg, xxh64_ctrl and xxh64_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): data_word, bytes_valid, last. Words of
//   a message are little-endian; non-last words count as 8 bytes.
//   Output channel (out_valid/out_ready): digest, one per message, after the
//   last word.
//   seed_we/seed_data write the seed; it is sampled at the first word of a
//   message.
//   Each 64-bit multiply is three 32x32 partial products.
//   A buffered word is accepted, then stored in the stripe buffer; a word
//   completing a stripe is accepted, then runs four lane rounds. The last
//   word adds a decode step (or the stripe update), merge (or the seed
//   start with no full stripe), length add, a fold per 8-byte word, one for
//   a 4-byte piece, one per byte, tail decode steps unless a full last word
//   was folded, and the mix; the digest then waits in its register.
//   No input is taken while a digest waits, so a stalled receiver stalls
//   the sender.
//   Reset clears the controller, byte count and lanes (seed zero).
module xxhash64_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [63:0] seed_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  bytes_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    logic [63:0]        seed_reg;
    xxh64_pkg::cmd_t    cmd;
    xxh64_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= 64'd0;
        else if (seed_we)
            seed_reg <= seed_data;
    end

    xxh64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    xxh64_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .digest      (digest)
    );

endmodule

@@ src/xxh64_checker.sv @@
// Port-level assertions for the XXH64 hasher, bound to the top level.
// Depends only on the top-level ports.
module xxh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest pending");

    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest))
        else $error("digest changed under stall");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("digest too early");

endmodule

bind xxhash64_stream_hasher_unit xxh64_checker u_xxh64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digest    (digest)
);
